// ===== src/gpps_pkg.sv =====
// ----------------------------------------------------------------------------
// gpps_pkg
// Types and constants for the gantry pick-and-place sequencer.
// ----------------------------------------------------------------------------
package gpps_pkg;

  localparam int POS_W   = 24;
  localparam int SPEED_W = 16;
  localparam int DT_W    = 10;
  localparam int STEP_W  = SPEED_W + DT_W;
  localparam int TIMER_W = 16;
  localparam int TYPE_W  = 8;
  localparam int CODE_W  = 4;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_START = 2'd1,
    OP_STOP  = 2'd2,
    OP_AUTO  = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PICKUP_X  = 3'd0,
    CFG_DROP_X    = 3'd1,
    CFG_Z_HOME    = 3'd2,
    CFG_Z_PICKUP  = 3'd3,
    CFG_Z_DROP    = 3'd4,
    CFG_X_SPEED   = 3'd5,
    CFG_Z_SPEED   = 3'd6,
    CFG_GRIP_TIME = 3'd7
  } cfg_idx_t;

  typedef enum logic [8:0] {
    ST_IDLE      = 9'b0_0000_0001,
    ST_MOVE_PICK = 9'b0_0000_0010,
    ST_LOWER_PK  = 9'b0_0000_0100,
    ST_GRIP      = 9'b0_0000_1000,
    ST_LIFT      = 9'b0_0001_0000,
    ST_MOVE_DROP = 9'b0_0010_0000,
    ST_LOWER_DR  = 9'b0_0100_0000,
    ST_RELEASE   = 9'b0_1000_0000,
    ST_LIFT_HOME = 9'b1_0000_0000
  } stage_t;

  localparam logic [CODE_W-1:0] CODE_IDLE      = 4'd0;
  localparam logic [CODE_W-1:0] CODE_MOVE_PICK = 4'd1;
  localparam logic [CODE_W-1:0] CODE_LOWER_PK  = 4'd2;
  localparam logic [CODE_W-1:0] CODE_GRIP      = 4'd3;
  localparam logic [CODE_W-1:0] CODE_LIFT      = 4'd4;
  localparam logic [CODE_W-1:0] CODE_MOVE_DROP = 4'd5;
  localparam logic [CODE_W-1:0] CODE_LOWER_DR  = 4'd6;
  localparam logic [CODE_W-1:0] CODE_RELEASE   = 4'd7;
  localparam logic [CODE_W-1:0] CODE_LIFT_HOME = 4'd8;

  function automatic logic [CODE_W-1:0] stage_code(input stage_t s);
    logic [CODE_W-1:0] c;
    case (s)
      ST_IDLE:      c = CODE_IDLE;
      ST_MOVE_PICK: c = CODE_MOVE_PICK;
      ST_LOWER_PK:  c = CODE_LOWER_PK;
      ST_GRIP:      c = CODE_GRIP;
      ST_LIFT:      c = CODE_LIFT;
      ST_MOVE_DROP: c = CODE_MOVE_DROP;
      ST_LOWER_DR:  c = CODE_LOWER_DR;
      ST_RELEASE:   c = CODE_RELEASE;
      ST_LIFT_HOME: c = CODE_LIFT_HOME;
      default:      c = CODE_IDLE;
    endcase
    return c;
  endfunction

endpackage

// ===== src/gantry_pick_place_sequencer_top.sv =====
// ----------------------------------------------------------------------------
// gantry_pick_place_sequencer_top
// Two-axis gantry pick-and-place sequencer with valid/ready request channels.
// ----------------------------------------------------------------------------
// Each request (tick, start, stop, set auto) yields exactly one result. A new
// request is accepted every cycle unless the result register is held. The
// input register captures the request together with speed*dt for both axes;
// the result register loads after one axis move (subtract, compare, add),
// the stage step and the timer. It holds while out_ready is low and the
// pipeline stalls behind it. The user must write configuration registers only
// while no request is in flight; the block itself does not enforce this.
module gantry_pick_place_sequencer_top import gpps_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [POS_W-1:0]          cfg_wdata,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                in_op,
  input  logic [DT_W-1:0]           in_dt_ms,
  input  logic                      in_auto_enable,
  input  logic                      in_part_present,
  input  logic [TYPE_W-1:0]         in_part_type,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [POS_W-1:0]   out_x_position,
  output logic signed [POS_W-1:0]   out_z_position,
  output logic [CODE_W-1:0]         out_stage_code,
  output logic                      out_gripper_closed,
  output logic                      out_carrying,
  output logic [TYPE_W-1:0]         out_held_type,
  output logic                      out_take_request,
  output logic                      out_drop_valid,
  output logic [TYPE_W-1:0]         out_drop_type,
  output logic                      out_auto_on
);

  // configuration
  logic [POS_W-1:0]   pickup_x_r, drop_x_r, z_home_r, z_pickup_r, z_drop_r;
  logic [SPEED_W-1:0] x_speed_r, z_speed_r, grip_settle_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pickup_x_r    <= '0;
      drop_x_r      <= '0;
      z_home_r      <= '0;
      z_pickup_r    <= '0;
      z_drop_r      <= '0;
      x_speed_r     <= '0;
      z_speed_r     <= '0;
      grip_settle_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_PICKUP_X:  pickup_x_r    <= cfg_wdata;
        CFG_DROP_X:    drop_x_r      <= cfg_wdata;
        CFG_Z_HOME:    z_home_r      <= cfg_wdata;
        CFG_Z_PICKUP:  z_pickup_r    <= cfg_wdata;
        CFG_Z_DROP:    z_drop_r      <= cfg_wdata;
        CFG_X_SPEED:   x_speed_r     <= cfg_wdata[SPEED_W-1:0];
        CFG_Z_SPEED:   z_speed_r     <= cfg_wdata[SPEED_W-1:0];
        CFG_GRIP_TIME: grip_settle_r <= cfg_wdata[SPEED_W-1:0];
        default: ;
      endcase
    end
  end

  // input register stage
  logic              s1_valid_r;
  op_t               s1_op_r;
  logic [DT_W-1:0]   s1_dt_r;
  logic              s1_auto_r;
  logic              s1_present_r;
  logic [TYPE_W-1:0] s1_ptype_r;
  logic [STEP_W-1:0] s1_xstep_r, s1_zstep_r;

  logic out_valid_r;
  logic advance;

  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_op_r      <= op_t'(in_op);
      s1_dt_r      <= in_dt_ms;
      s1_auto_r    <= in_auto_enable;
      s1_present_r <= in_part_present;
      s1_ptype_r   <= in_part_type;
      s1_xstep_r   <= STEP_W'(x_speed_r) * STEP_W'(in_dt_ms);
      s1_zstep_r   <= STEP_W'(z_speed_r) * STEP_W'(in_dt_ms);
    end
  end

  // sequencer state
  stage_t             stage_r, stage_nxt;
  logic [POS_W-1:0]   x_now_r, x_now_nxt, z_now_r, z_now_nxt;
  logic [TIMER_W-1:0] timer_r, timer_nxt;
  logic running_r, running_nxt, auto_r, auto_nxt, homed_r, homed_nxt;
  logic gripped_r, gripped_nxt, pend_v_r, pend_v_nxt, held_v_r, held_v_nxt;
  logic [TYPE_W-1:0]  pend_t_r, pend_t_nxt, held_t_r, held_t_nxt;
  logic               take_nxt, drop_nxt;
  logic [TYPE_W-1:0]  dtype_nxt;

  // shared axis move: x in the travel stages, z otherwise
  logic               mv_is_x;
  logic [POS_W-1:0]   mv_pos, mv_tgt, mv_new;
  logic [STEP_W-1:0]  mv_step;
  logic signed [POS_W:0] mv_diff;
  logic [POS_W:0]     mv_mag;
  logic               mv_done;

  always_comb begin
    mv_is_x = (stage_r == ST_MOVE_PICK) || (stage_r == ST_MOVE_DROP);
    case (stage_r)
      ST_MOVE_PICK: mv_tgt = pickup_x_r;
      ST_MOVE_DROP: mv_tgt = drop_x_r;
      ST_LOWER_PK:  mv_tgt = z_pickup_r;
      ST_LOWER_DR:  mv_tgt = z_drop_r;
      default:      mv_tgt = z_home_r;
    endcase
    mv_pos  = mv_is_x ? x_now_r : z_now_r;
    mv_step = mv_is_x ? s1_xstep_r : s1_zstep_r;
    mv_diff = $signed({mv_tgt[POS_W-1], mv_tgt}) - $signed({mv_pos[POS_W-1], mv_pos});
    mv_mag  = mv_diff[POS_W] ? (POS_W+1)'(-mv_diff) : (POS_W+1)'(mv_diff);
    mv_done = {{(STEP_W-POS_W-1){1'b0}}, mv_mag} <= mv_step;
    // not done means step < mag <= 2^24, so the low bits of step suffice
    if (mv_done) begin
      mv_new = mv_tgt;
    end else if (mv_diff[POS_W]) begin
      mv_new = mv_pos - mv_step[POS_W-1:0];
    end else begin
      mv_new = mv_pos + mv_step[POS_W-1:0];
    end
  end

  logic [TIMER_W:0]   timer_sum;
  logic [TIMER_W-1:0] timer_sat;

  always_comb begin
    timer_sum = {1'b0, timer_r} + (TIMER_W+1)'(s1_dt_r);
    timer_sat = timer_sum[TIMER_W] ? {TIMER_W{1'b1}} : timer_sum[TIMER_W-1:0];
  end

  always_comb begin
    stage_nxt   = stage_r;
    x_now_nxt   = x_now_r;
    z_now_nxt   = z_now_r;
    timer_nxt   = timer_r;
    running_nxt = running_r;
    auto_nxt    = auto_r;
    homed_nxt   = homed_r;
    gripped_nxt = gripped_r;
    pend_v_nxt  = pend_v_r;
    pend_t_nxt  = pend_t_r;
    held_v_nxt  = held_v_r;
    held_t_nxt  = held_t_r;
    take_nxt    = 1'b0;
    drop_nxt    = 1'b0;
    dtype_nxt   = '0;
    case (s1_op_r)
      OP_START: begin
        if (!homed_r) begin
          x_now_nxt = pickup_x_r;
          z_now_nxt = z_home_r;
          homed_nxt = 1'b1;
        end
        running_nxt = 1'b1;
      end
      OP_STOP: begin
        running_nxt = 1'b0;
        stage_nxt   = ST_IDLE;
        timer_nxt   = '0;
        pend_v_nxt  = 1'b0;
        pend_t_nxt  = '0;
        held_v_nxt  = 1'b0;
        held_t_nxt  = '0;
        gripped_nxt = 1'b0;
      end
      OP_AUTO: begin
        auto_nxt = s1_auto_r;
      end
      default: begin
        if (running_r && auto_r) begin
          timer_nxt = timer_sat;
          if (mv_is_x) begin
            x_now_nxt = mv_new;
          end else begin
            z_now_nxt = mv_new;
          end
          case (stage_r)
            ST_IDLE: begin
              // the move result is discarded outside the move stages
              z_now_nxt = z_now_r;
              if (s1_present_r) begin
                pend_v_nxt = 1'b1;
                pend_t_nxt = s1_ptype_r;
                stage_nxt  = ST_MOVE_PICK;
                timer_nxt  = '0;
              end
            end
            ST_MOVE_PICK, ST_LIFT, ST_MOVE_DROP, ST_LOWER_DR, ST_LIFT_HOME: begin
              if (mv_done) begin
                timer_nxt = '0;
                case (stage_r)
                  ST_MOVE_PICK: stage_nxt = ST_LOWER_PK;
                  ST_LIFT:      stage_nxt = ST_MOVE_DROP;
                  ST_MOVE_DROP: stage_nxt = ST_LOWER_DR;
                  ST_LOWER_DR:  stage_nxt = ST_RELEASE;
                  default:      stage_nxt = ST_IDLE;
                endcase
              end
            end
            ST_LOWER_PK: begin
              if (mv_done) begin
                gripped_nxt = 1'b1;
                stage_nxt   = ST_GRIP;
                timer_nxt   = '0;
              end
            end
            ST_GRIP: begin
              z_now_nxt = z_now_r;
              if (timer_sat >= grip_settle_r) begin
                if (s1_present_r) begin
                  take_nxt   = 1'b1;
                  held_v_nxt = 1'b1;
                  held_t_nxt = s1_ptype_r;
                end else begin
                  held_v_nxt = pend_v_r;
                  held_t_nxt = pend_v_r ? pend_t_r : '0;
                end
                pend_v_nxt = 1'b0;
                pend_t_nxt = '0;
                stage_nxt  = ST_LIFT;
                timer_nxt  = '0;
              end
            end
            ST_RELEASE: begin
              z_now_nxt = z_now_r;
              if (held_v_r) begin
                drop_nxt  = 1'b1;
                dtype_nxt = held_t_r;
              end
              held_v_nxt  = 1'b0;
              held_t_nxt  = '0;
              gripped_nxt = 1'b0;
              stage_nxt   = ST_LIFT_HOME;
              timer_nxt   = '0;
            end
            default: begin
              z_now_nxt = z_now_r;
              stage_nxt = ST_IDLE;
              timer_nxt = '0;
            end
          endcase
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r   <= ST_IDLE;
      x_now_r   <= '0;
      z_now_r   <= '0;
      timer_r   <= '0;
      running_r <= 1'b0;
      auto_r    <= 1'b1;
      homed_r   <= 1'b0;
      gripped_r <= 1'b0;
      pend_v_r  <= 1'b0;
      pend_t_r  <= '0;
      held_v_r  <= 1'b0;
      held_t_r  <= '0;
    end else if (advance) begin
      stage_r   <= stage_nxt;
      x_now_r   <= x_now_nxt;
      z_now_r   <= z_now_nxt;
      timer_r   <= timer_nxt;
      running_r <= running_nxt;
      auto_r    <= auto_nxt;
      homed_r   <= homed_nxt;
      gripped_r <= gripped_nxt;
      pend_v_r  <= pend_v_nxt;
      pend_t_r  <= pend_t_nxt;
      held_v_r  <= held_v_nxt;
      held_t_r  <= held_t_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_x_position     <= x_now_nxt;
      out_z_position     <= z_now_nxt;
      out_stage_code     <= stage_code(stage_nxt);
      out_gripper_closed <= gripped_nxt;
      out_carrying       <= held_v_nxt;
      out_held_type      <= held_v_nxt ? held_t_nxt : '0;
      out_take_request   <= take_nxt;
      out_drop_valid     <= drop_nxt;
      out_drop_type      <= dtype_nxt;
      out_auto_on        <= auto_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // checks
  a_drop_stage: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_drop_valid) |->
      (out_stage_code == CODE_LIFT_HOME && !out_gripper_closed && !out_carrying))
    else $error("drop request outside release");

  a_take_stage: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_take_request) |->
      (out_stage_code == CODE_LIFT && out_carrying && out_gripper_closed))
    else $error("take request outside grip end");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> ($stable(stage_r) && $stable(x_now_r) && $stable(z_now_r)))
    else $error("sequencer state moved without a request");

  a_held_in_carry: assert property (@(posedge clk) disable iff (!rst_n)
    held_v_r |-> (stage_r == ST_LIFT || stage_r == ST_MOVE_DROP ||
                  stage_r == ST_LOWER_DR || stage_r == ST_RELEASE))
    else $error("part held outside carry stages");

  a_grip_stages: assert property (@(posedge clk) disable iff (!rst_n)
    gripped_r |-> !(stage_r == ST_IDLE || stage_r == ST_MOVE_PICK ||
                    stage_r == ST_LOWER_PK || stage_r == ST_LIFT_HOME))
    else $error("gripper closed outside grip stages");

endmodule

// ===== verif/gantry_pick_place_sequencer_checker.sv =====
// ----------------------------------------------------------------------------
// gantry_pick_place_sequencer_checker
// Watches the config port and both request channels of the gantry sequencer.
// It keeps its own copy of the sequencer state, works out the status that
// each accepted request should return, and compares every returned status
// with the oldest one still waiting.
// ----------------------------------------------------------------------------
module gantry_pick_place_sequencer_checker import gpps_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [POS_W-1:0]        cfg_wdata,
  input  logic                    in_valid,
  input  logic                    in_ready,
  input  logic [1:0]              in_op,
  input  logic [DT_W-1:0]         in_dt_ms,
  input  logic                    in_auto_enable,
  input  logic                    in_part_present,
  input  logic [TYPE_W-1:0]       in_part_type,
  input  logic                    out_valid,
  input  logic                    out_ready,
  input  logic signed [POS_W-1:0] out_x_position,
  input  logic signed [POS_W-1:0] out_z_position,
  input  logic [CODE_W-1:0]       out_stage_code,
  input  logic                    out_gripper_closed,
  input  logic                    out_carrying,
  input  logic [TYPE_W-1:0]       out_held_type,
  input  logic                    out_take_request,
  input  logic                    out_drop_valid,
  input  logic [TYPE_W-1:0]       out_drop_type,
  input  logic                    out_auto_on,
  output int                      err_count,
  output int                      n_open
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TIMER_TOP = (1 << TIMER_W) - 1;

  typedef struct packed {
    logic signed [POS_W-1:0] x_position;
    logic signed [POS_W-1:0] z_position;
    logic [CODE_W-1:0]       stage_code;
    logic                    gripper_closed;
    logic                    carrying;
    logic [TYPE_W-1:0]       held_type;
    logic                    take_request;
    logic                    drop_valid;
    logic [TYPE_W-1:0]       drop_type;
    logic                    auto_on;
  } gantry_status_t;

  gantry_status_t status_q[$];

  // setup registers
  logic signed [POS_W-1:0] pick_x_r, drop_x_r, z_home_r, z_pick_r, z_drop_r;
  logic [SPEED_W-1:0]      x_speed_r, z_speed_r, grip_ms_r;

  // sequencer state
  logic [CODE_W-1:0]       stage_q;
  logic signed [POS_W-1:0] x_pos, z_pos;
  int unsigned             stage_ms;
  logic                    running, auto_flag, homed, gripped;
  logic                    pend_v, held_v;
  logic [TYPE_W-1:0]       pend_t, held_t;

  function automatic void enter_stage(input logic [CODE_W-1:0] code);
    stage_q  = code;
    stage_ms = 0;
  endfunction

  // Moves pos toward tgt by spd*dt, snapping when within one step.
  function automatic logic axis_step(inout logic signed [POS_W-1:0] pos,
                                     input logic signed [POS_W-1:0] tgt,
                                     input logic [SPEED_W-1:0] spd,
                                     input logic [DT_W-1:0] dt);
    longint stride, gap, span;
    stride = longint'(spd) * longint'(dt);
    gap    = longint'(tgt) - longint'(pos);
    span   = (gap < 0) ? -gap : gap;
    if (span <= stride) begin
      pos = tgt;
      return 1'b1;
    end
    pos = (gap > 0) ? POS_W'(longint'(pos) + stride) : POS_W'(longint'(pos) - stride);
    return 1'b0;
  endfunction

  function automatic gantry_status_t advance_gantry(input op_t op,
                                                    input logic [DT_W-1:0] dt,
                                                    input logic en,
                                                    input logic present,
                                                    input logic [TYPE_W-1:0] ptype);
    gantry_status_t r;
    logic take, drop;
    logic [TYPE_W-1:0] dtype;
    int unsigned sum;
    take  = 1'b0;
    drop  = 1'b0;
    dtype = '0;
    case (op)
      OP_START: begin
        if (!homed) begin
          x_pos = pick_x_r;
          z_pos = z_home_r;
          homed = 1'b1;
        end
        running = 1'b1;
      end
      OP_STOP: begin
        running = 1'b0;
        enter_stage(CODE_IDLE);
        pend_v  = 1'b0;
        pend_t  = '0;
        held_v  = 1'b0;
        held_t  = '0;
        gripped = 1'b0;
      end
      OP_AUTO: auto_flag = en;
      default: if (running && auto_flag) begin
        sum = stage_ms + dt;
        stage_ms = (sum > TIMER_TOP) ? TIMER_TOP : sum;
        case (stage_q)
          CODE_IDLE: if (present) begin
            pend_v = 1'b1;
            pend_t = ptype;
            enter_stage(CODE_MOVE_PICK);
          end
          CODE_MOVE_PICK:
            if (axis_step(x_pos, pick_x_r, x_speed_r, dt)) enter_stage(CODE_LOWER_PK);
          CODE_LOWER_PK: if (axis_step(z_pos, z_pick_r, z_speed_r, dt)) begin
            gripped = 1'b1;
            enter_stage(CODE_GRIP);
          end
          CODE_GRIP: if (stage_ms >= grip_ms_r) begin
            // with no part at the conveyor end, keep the one seen at idle
            if (present) begin
              take   = 1'b1;
              held_v = 1'b1;
              held_t = ptype;
            end else begin
              held_v = pend_v;
              held_t = pend_v ? pend_t : '0;
            end
            pend_v = 1'b0;
            pend_t = '0;
            enter_stage(CODE_LIFT);
          end
          CODE_LIFT:
            if (axis_step(z_pos, z_home_r, z_speed_r, dt)) enter_stage(CODE_MOVE_DROP);
          CODE_MOVE_DROP:
            if (axis_step(x_pos, drop_x_r, x_speed_r, dt)) enter_stage(CODE_LOWER_DR);
          CODE_LOWER_DR:
            if (axis_step(z_pos, z_drop_r, z_speed_r, dt)) enter_stage(CODE_RELEASE);
          CODE_RELEASE: begin
            if (held_v) begin
              drop  = 1'b1;
              dtype = held_t;
            end
            held_v  = 1'b0;
            held_t  = '0;
            gripped = 1'b0;
            enter_stage(CODE_LIFT_HOME);
          end
          CODE_LIFT_HOME:
            if (axis_step(z_pos, z_home_r, z_speed_r, dt)) enter_stage(CODE_IDLE);
          default: enter_stage(CODE_IDLE);
        endcase
      end
    endcase
    r.x_position     = x_pos;
    r.z_position     = z_pos;
    r.stage_code     = stage_q;
    r.gripper_closed = gripped;
    r.carrying       = held_v;
    r.held_type      = held_v ? held_t : '0;
    r.take_request   = take;
    r.drop_valid     = drop;
    r.drop_type      = dtype;
    r.auto_on        = auto_flag;
    return r;
  endfunction

  function automatic string fmt_status(input gantry_status_t s);
    return $sformatf("x=%0d z=%0d stage=%0d grip=%0b carry=%0b held=%02h take=%0b drop=%0b/%02h auto=%0b",
                     $signed(s.x_position), $signed(s.z_position), s.stage_code,
                     s.gripper_closed, s.carrying, s.held_type, s.take_request,
                     s.drop_valid, s.drop_type, s.auto_on);
  endfunction

  always @(posedge clk) begin
    gantry_status_t seen, want;
    if (!rst_n) begin
      pick_x_r  = '0;
      drop_x_r  = '0;
      z_home_r  = '0;
      z_pick_r  = '0;
      z_drop_r  = '0;
      x_speed_r = '0;
      z_speed_r = '0;
      grip_ms_r = '0;
      stage_q   = CODE_IDLE;
      x_pos     = '0;
      z_pos     = '0;
      stage_ms  = 0;
      running   = 1'b0;
      auto_flag = 1'b1;
      homed     = 1'b0;
      gripped   = 1'b0;
      pend_v    = 1'b0;
      pend_t    = '0;
      held_v    = 1'b0;
      held_t    = '0;
      err_count = 0;
      status_q.delete();
      n_open <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_PICKUP_X:  pick_x_r  = cfg_wdata;
          CFG_DROP_X:    drop_x_r  = cfg_wdata;
          CFG_Z_HOME:    z_home_r  = cfg_wdata;
          CFG_Z_PICKUP:  z_pick_r  = cfg_wdata;
          CFG_Z_DROP:    z_drop_r  = cfg_wdata;
          CFG_X_SPEED:   x_speed_r = cfg_wdata[SPEED_W-1:0];
          CFG_Z_SPEED:   z_speed_r = cfg_wdata[SPEED_W-1:0];
          CFG_GRIP_TIME: grip_ms_r = cfg_wdata[SPEED_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        seen.x_position     = out_x_position;
        seen.z_position     = out_z_position;
        seen.stage_code     = out_stage_code;
        seen.gripper_closed = out_gripper_closed;
        seen.carrying       = out_carrying;
        seen.held_type      = out_held_type;
        seen.take_request   = out_take_request;
        seen.drop_valid     = out_drop_valid;
        seen.drop_type      = out_drop_type;
        seen.auto_on        = out_auto_on;
        if (status_q.size() == 0) begin
          err_count++;
          if (err_count <= 10)
            $display("%t: status with no request waiting: %s", $realtime, fmt_status(seen));
        end else begin
          want = status_q.pop_front();
          if (seen !== want) begin
            err_count++;
            if (err_count <= 10) begin
              $display("%t: status mismatch", $realtime);
              $display("  expected %s", fmt_status(want));
              $display("  actual   %s", fmt_status(seen));
            end
          end
        end
      end
      if (in_valid && in_ready)
        status_q.push_back(advance_gantry(op_t'(in_op), in_dt_ms, in_auto_enable,
                                          in_part_present, in_part_type));
      n_open <= status_q.size();
    end
  end

endmodule

// ===== verif/gantry_pick_place_sequencer_top_tb.sv =====
// ----------------------------------------------------------------------------
// gantry_pick_place_sequencer_top_tb
// Drives tick, start, stop and auto requests into the gantry sequencer under
// several register setups, with bursty input, a stalling receiver and one
// long receiver hold-off; the checker beside the block scores the results.
// ----------------------------------------------------------------------------
module gantry_pick_place_sequencer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import gpps_pkg::*;

  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_AT     = 1200;
  localparam int HOLD_LEN    = 400;
  localparam int RX_FREE     = 0;
  localparam int RX_COIN     = 1;
  localparam int RX_SPARSE   = 2;
  localparam int RX_PULSE    = 3;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [POS_W-1:0]        cfg_wdata = '0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [1:0]              in_op = OP_TICK;
  logic [DT_W-1:0]         in_dt_ms = '0;
  logic                    in_auto_enable = 1'b0;
  logic                    in_part_present = 1'b0;
  logic [TYPE_W-1:0]       in_part_type = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic signed [POS_W-1:0] out_x_position, out_z_position;
  logic [CODE_W-1:0]       out_stage_code;
  logic                    out_gripper_closed, out_carrying;
  logic [TYPE_W-1:0]       out_held_type;
  logic                    out_take_request, out_drop_valid;
  logic [TYPE_W-1:0]       out_drop_type;
  logic                    out_auto_on;

  int err_count;
  int n_open;
  int quiet = 0;
  int burst_left = 0;
  logic [POS_W-1:0] setup_val [8];

  initial begin
    forever #2 clk = ~clk;
  end

  gantry_pick_place_sequencer_top u_top (.*);

  gantry_pick_place_sequencer_checker u_checker (.*);

  // receiver: changing stall patterns, plus one long hold-off
  initial begin
    int cyc, mode, left;
    cyc  = 0;
    mode = RX_FREE;
    left = 0;
    forever begin
      @(posedge clk);
      cyc++;
      if (left == 0) begin
        mode = $urandom_range(RX_FREE, RX_PULSE);
        left = $urandom_range(40, 200);
      end
      left--;
      if (cyc >= HOLD_AT && cyc < HOLD_AT + HOLD_LEN) out_ready <= 1'b0;
      else begin
        case (mode)
          RX_FREE:   out_ready <= 1'b1;
          RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
          RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
          default:   out_ready <= (cyc % 8 < 3);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet <= 0;
    else if (quiet == QUIET_LIMIT) begin
      $display("gantry_pick_place_sequencer_top_tb: done, errors");
      $finish;
    end else quiet <= quiet + 1;
  end

  task automatic offer(input op_t op, input logic [DT_W-1:0] dt, input logic en,
                       input logic pp, input logic [TYPE_W-1:0] pt);
    int gap;
    in_valid        <= 1'b1;
    in_op           <= op;
    in_dt_ms        <= dt;
    in_auto_enable  <= en;
    in_part_present <= pp;
    in_part_type    <= pt;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (burst_left > 0) burst_left--;
    else begin
      burst_left = $urandom_range(0, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // wait until every request has its status back, plus pipeline slack
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (n_open != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_setup();
    for (int i = int'(CFG_PICKUP_X); i <= int'(CFG_GRIP_TIME); i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_wdata <= setup_val[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic logic [POS_W-1:0] rand_pos(input int reach);
    if (reach == 0) return POS_W'($urandom);
    return POS_W'(int'($urandom_range(0, 2 * reach)) - reach);
  endfunction

  // 16-bit register value; upper write-data bits are junk
  function automatic logic [POS_W-1:0] rand_word(input int lo, input int hi);
    return {8'($urandom), 16'($urandom_range(lo, hi))};
  endfunction

  function automatic void near_setup(input int reach, input int lo_spd, input int hi_spd,
                                     input int hi_grip);
    setup_val[CFG_PICKUP_X]  = rand_pos(reach);
    setup_val[CFG_DROP_X]    = rand_pos(reach);
    setup_val[CFG_Z_HOME]    = rand_pos(reach);
    setup_val[CFG_Z_PICKUP]  = rand_pos(reach);
    setup_val[CFG_Z_DROP]    = rand_pos(reach);
    setup_val[CFG_X_SPEED]   = rand_word(lo_spd, hi_spd);
    setup_val[CFG_Z_SPEED]   = rand_word(lo_spd, hi_spd);
    setup_val[CFG_GRIP_TIME] = rand_word(0, hi_grip);
  endfunction

  task automatic run_phase(input int count, input int stop_pct);
    int r, s;
    op_t op;
    logic [DT_W-1:0] dt;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < 5) op = OP_START;
      else if (r < 5 + stop_pct) op = OP_STOP;
      else if (r < 10 + stop_pct) op = OP_AUTO;
      else op = OP_TICK;
      s = $urandom_range(0, 19);
      if (s == 0) dt = '0;
      else if (s == 1) dt = DT_W'($urandom_range(1001, 1023));
      else if (s < 6) dt = DT_W'($urandom_range(1, 20));
      else dt = DT_W'($urandom_range(0, 1000));
      offer(op, dt, $urandom_range(0, 3) != 0, $urandom_range(0, 9) < 7,
            TYPE_W'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // reset setup: all zero, so every move arrives at once
    offer(OP_TICK,  10'd1023, 1'b0, 1'b1, 8'hFF);  // not started yet
    offer(OP_AUTO,  10'd0,    1'b0, 1'b0, 8'h00);
    offer(OP_START, 10'd0,    1'b0, 1'b0, 8'h00);  // first start homes
    offer(OP_TICK,  10'd500,  1'b0, 1'b1, 8'h11);  // auto off: halted
    offer(OP_AUTO,  10'd0,    1'b1, 1'b0, 8'h00);
    offer(OP_TICK,  10'd0,    1'b0, 1'b0, 8'h00);
    offer(OP_TICK,  10'd1,    1'b0, 1'b1, 8'hA5);
    offer(OP_TICK,  10'd0,    1'b0, 1'b0, 8'h00);  // zero speed, already there
    offer(OP_TICK,  10'd0,    1'b0, 1'b0, 8'h00);
    offer(OP_TICK,  10'd0,    1'b0, 1'b0, 8'h00);  // grip ends with no part
    for (int i = 0; i < 5; i++) offer(OP_TICK, 10'd7, 1'b1, 1'b0, 8'h5A);
    offer(OP_TICK,  10'd3,    1'b1, 1'b1, 8'h3C);
    offer(OP_TICK,  10'd3,    1'b0, 1'b1, 8'h3C);
    offer(OP_TICK,  10'd3,    1'b0, 1'b1, 8'h3C);
    offer(OP_TICK,  10'd3,    1'b0, 1'b1, 8'hC3);  // part taken at grip
    offer(OP_TICK,  10'd3,    1'b0, 1'b0, 8'h00);
    offer(OP_STOP,  10'd999,  1'b0, 1'b1, 8'h77);  // stop mid-sequence
    offer(OP_TICK,  10'd1000, 1'b1, 1'b1, 8'h77);

    drain();
    setup_val[CFG_PICKUP_X]  = 24'h800000;
    setup_val[CFG_DROP_X]    = 24'h7FFFFF;
    setup_val[CFG_Z_HOME]    = 24'h7FFFFF;
    setup_val[CFG_Z_PICKUP]  = 24'h800000;
    setup_val[CFG_Z_DROP]    = 24'h000000;
    setup_val[CFG_X_SPEED]   = 24'hA5FFFF;
    setup_val[CFG_Z_SPEED]   = 24'h00FFFF;
    setup_val[CFG_GRIP_TIME] = 24'h0003E8;
    load_setup();
    offer(OP_START, 10'd0,    1'b0, 1'b0, 8'h00);  // already homed
    offer(OP_TICK,  10'd1000, 1'b0, 1'b1, 8'h00);
    offer(OP_TICK,  10'd1023, 1'b0, 1'b1, 8'hFF);  // full-scale x move

    drain();
    near_setup(20000, 2000, 65535, 3000);
    load_setup();
    run_phase(306, 3);

    // slow axes: moves take several ticks
    drain();
    near_setup(20000, 1, 40, 300);
    load_setup();
    run_phase(306, 2);

    // opposite extremes, longest grip settle so the timer saturates
    drain();
    setup_val[CFG_PICKUP_X]  = 24'h7FFFFF;
    setup_val[CFG_DROP_X]    = 24'h800000;
    setup_val[CFG_Z_HOME]    = 24'h800000;
    setup_val[CFG_Z_PICKUP]  = 24'h7FFFFF;
    setup_val[CFG_Z_DROP]    = 24'h7FFFFF;
    setup_val[CFG_X_SPEED]   = 24'h5AFFFF;
    setup_val[CFG_Z_SPEED]   = 24'hFFFFFF;
    setup_val[CFG_GRIP_TIME] = 24'h00FFFF;
    load_setup();
    run_phase(306, 0);

    drain();
    near_setup(0, 0, 65535, 5000);
    if ($urandom_range(0, 99) < 15) setup_val[CFG_X_SPEED] = rand_word(0, 0);
    if ($urandom_range(0, 99) < 15) setup_val[CFG_Z_SPEED] = rand_word(0, 0);
    load_setup();
    run_phase(306, 3);

    drain();
    near_setup(50000, 300, 3000, 2000);
    load_setup();
    run_phase(306, 3);

    drain();
    if (err_count == 0 && n_open == 0) begin
      $display("gantry_pick_place_sequencer_top_tb: done, clean");
    end else begin
      $display("gantry_pick_place_sequencer_top_tb: done, errors");
    end
    $finish;
  end

endmodule
